FILE: rtl/assert_macros.svh
// Assertion helpers; clock and reset come from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/ebd_pkg.sv
package ebd_pkg;

   localparam logic [31:0] LIMIT_SECONDS   = 32'd3155760000;
   localparam logic [9:0]  DAY_DIVISOR     = 10'd675;        // 86400 >> 7
   localparam logic [25:0] DAY_RECIP       = 26'd50903316;   // floor(2^35 / 675)
   localparam logic [9:0]  MIN_DIVISOR     = 10'd15;         // 60 >> 2
   localparam logic [25:0] MIN_RECIP       = 26'd69905;      // floor(2^20 / 15)
   localparam logic [9:0]  WEEK_DIVISOR    = 10'd7;
   localparam logic [25:0] WEEK_RECIP      = 26'd149796;     // floor(2^20 / 7)
   localparam logic [6:0]  YEAR_SPAN       = 7'd100;
   localparam logic [7:0]  YEAR_BASE_OFS   = 8'd70;
   localparam logic [3:0]  LAST_MONTH      = 4'd11;
   localparam logic [3:0]  FEBRUARY        = 4'd1;

   localparam logic [1:0] OP_DAY  = 2'd0;
   localparam logic [1:0] OP_SEC  = 2'd1;
   localparam logic [1:0] OP_MIN  = 2'd2;
   localparam logic [1:0] OP_WEEK = 2'd3;

   typedef struct packed {
      logic       load;
      logic       div_start;
      logic [1:0] div_op;
      logic       year_en;
      logic       month_en;
      logic       emit;
   } cmd_type;

   typedef struct packed {
      logic oor;
      logic div_done;
      logic year_done;
      logic month_done;
   } sts_type;

   function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
      logic [4:0] len;
      case (m)
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd3:    len = 5'd30;
         4'd5:    len = 5'd30;
         4'd8:    len = 5'd30;
         4'd10:   len = 5'd30;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

   // v < 100: tens = (v * 103) >> 10
   function automatic logic [7:0] to_bcd(input logic [6:0] v);
      logic [13:0] p;
      logic [3:0]  tens;
      logic [6:0]  tens_x10;
      logic [6:0]  ones;
      p        = {7'd0, v} * 14'd103;
      tens     = p[13:10];
      tens_x10 = ({3'd0, tens} << 3) + ({3'd0, tens} << 1);
      ones     = v - tens_x10;
      return {tens, ones[3:0]};
   endfunction

endpackage

FILE: rtl/epoch_seconds_to_bcd_date_top.sv
// Sequence: rsp_valid rises after the four divides and a walk over the years and months
// (at most 99 years and 11 months); out-of-range items skip the divides and the walks.
// One item at a time: busy is high until the result register loads, and the next start is
// taken while rsp_valid is shown, so a new item is not accepted before the last one is done.
// The receiver cannot stall. Synchronous active-high reset returns to idle with no result
// pending.
module epoch_seconds_to_bcd_date_top import ebd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [6:0]  rsp_second_bcd,
   output logic [6:0]  rsp_minute_bcd,
   output logic [5:0]  rsp_hour_bcd,
   output logic [2:0]  rsp_weekday,
   output logic [5:0]  rsp_day_bcd,
   output logic [4:0]  rsp_month_bcd,
   output logic [7:0]  rsp_year_bcd,
   output logic        rsp_out_of_range
);

   cmd_type cmd;
   sts_type sts;

   ebd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .sts   (sts)
   );

   ebd_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_epoch_seconds (req_epoch_seconds),
      .rsp_valid         (rsp_valid),
      .rsp_second_bcd    (rsp_second_bcd),
      .rsp_minute_bcd    (rsp_minute_bcd),
      .rsp_hour_bcd      (rsp_hour_bcd),
      .rsp_weekday       (rsp_weekday),
      .rsp_day_bcd       (rsp_day_bcd),
      .rsp_month_bcd     (rsp_month_bcd),
      .rsp_year_bcd      (rsp_year_bcd),
      .rsp_out_of_range  (rsp_out_of_range)
   );

endmodule

FILE: rtl/ebd_div.sv
`include "assert_macros.svh"

// Divide by a constant: strip the power of two, multiply by the reciprocal of the odd
// part, then one compare and subtract (the estimate is low by at most one).
module ebd_div import ebd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  op,
   input  logic [31:0] dividend,
   output logic        done,
   output logic [15:0] quotient,
   output logic [16:0] remainder
);

   logic [1:0]  op_ff, op_in;
   logic [24:0] x_ff, x_in;
   logic [6:0]  low_ff, low_in;
   logic [50:0] prod_ff, prod_in;
   logic [15:0] qe_ff, qe_in;
   logic [10:0] r_ff, r_in;
   logic [15:0] q_ff, q_in;
   logic [16:0] rem_ff, rem_in;
   logic [2:0]  stage_ff, stage_in;
   logic        done_ff, done_in;

   logic [9:0]  dsr;
   logic [25:0] recip;
   logic [15:0] q_est;
   logic [25:0] qd;
   logic [25:0] r_wide;
   logic        fix;
   logic [10:0] r_fix;

   always_comb begin
      case (op_ff)
         OP_DAY: begin
            dsr   = DAY_DIVISOR;
            recip = DAY_RECIP;
         end
         OP_WEEK: begin
            dsr   = WEEK_DIVISOR;
            recip = WEEK_RECIP;
         end
         default: begin
            dsr   = MIN_DIVISOR;
            recip = MIN_RECIP;
         end
      endcase
   end

   assign q_est  = (op_ff == OP_DAY) ? prod_ff[50:35] : prod_ff[35:20];
   assign qd     = {10'd0, q_est} * {16'd0, dsr};
   assign r_wide = {1'b0, x_ff} - qd;
   assign fix    = r_ff >= {1'b0, dsr};
   assign r_fix  = fix ? r_ff - {1'b0, dsr} : r_ff;

   always_comb begin
      op_in    = op_ff;
      x_in     = x_ff;
      low_in   = low_ff;
      prod_in  = {26'd0, x_ff} * {25'd0, recip};
      qe_in    = q_est;
      r_in     = r_wide[10:0];
      q_in     = q_ff;
      rem_in   = rem_ff;
      stage_in = {stage_ff[1:0], start};
      done_in  = stage_ff[2];
      if (start) begin
         op_in  = op;
         low_in = dividend[6:0];
         case (op)
            OP_DAY:  x_in = dividend[31:7];
            OP_WEEK: x_in = {8'd0, dividend[16:0]};
            default: x_in = {10'd0, dividend[16:2]};
         endcase
      end
      if (stage_ff[2]) begin
         q_in = qe_ff + {15'd0, fix};
         case (op_ff)
            OP_DAY:  rem_in = {r_fix[9:0], low_ff};
            OP_WEEK: rem_in = {14'd0, r_fix[2:0]};
            default: rem_in = {11'd0, r_fix[3:0], low_ff[1:0]};
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      x_ff    <= x_in;
      low_ff  <= low_in;
      prod_ff <= prod_in;
      qe_ff   <= qe_in;
      r_ff    <= r_in;
      q_ff    <= q_in;
      rem_ff  <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = q_ff;
   assign remainder = rem_ff;

   `ASSERT_IMPLIES(a_no_restart, start, stage_ff == 3'd0, "divider restarted while running")
   `ASSERT_IMPLIES(a_est_close, stage_ff[2], r_ff < {dsr, 1'b0}, "quotient estimate off by two")

endmodule

FILE: rtl/ebd_dp.sv
`include "assert_macros.svh"

module ebd_dp import ebd_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output sts_type     sts,
   input  logic [31:0] req_epoch_seconds,
   output logic        rsp_valid,
   output logic [6:0]  rsp_second_bcd,
   output logic [6:0]  rsp_minute_bcd,
   output logic [5:0]  rsp_hour_bcd,
   output logic [2:0]  rsp_weekday,
   output logic [5:0]  rsp_day_bcd,
   output logic [4:0]  rsp_month_bcd,
   output logic [7:0]  rsp_year_bcd,
   output logic        rsp_out_of_range
);

   logic [31:0] t_ff, t_in;
   logic [15:0] days_ff, days_in;
   logic [16:0] tod_ff, tod_in;
   logic [10:0] mt_ff, mt_in;
   logic [5:0]  sec_ff, sec_in;
   logic [5:0]  min_ff, min_in;
   logic [4:0]  hour_ff, hour_in;
   logic [2:0]  wd_ff, wd_in;
   logic [6:0]  yo_ff, yo_in;
   logic [3:0]  mon_ff, mon_in;
   logic        valid_ff, valid_in;
   logic [6:0]  o_sec_ff, o_sec_in;
   logic [6:0]  o_min_ff, o_min_in;
   logic [5:0]  o_hour_ff, o_hour_in;
   logic [2:0]  o_wd_ff, o_wd_in;
   logic [5:0]  o_day_ff, o_day_in;
   logic [4:0]  o_mon_ff, o_mon_in;
   logic [7:0]  o_year_ff, o_year_in;
   logic        o_oor_ff, o_oor_in;

   logic [31:0] div_dividend;
   logic        div_done;
   logic [15:0] div_q;
   logic [16:0] div_r;

   logic        oor;
   logic [6:0]  yo_plus2;
   logic        leap;
   logic [8:0]  ydays;
   logic        year_step;
   logic [4:0]  mlen;
   logic        month_step;
   logic [16:0] days_plus4;
   logic [7:0]  yy_full;
   logic [6:0]  yy;
   logic [7:0]  bcd_sec, bcd_min, bcd_hour, bcd_day, bcd_mon, bcd_year;

   assign oor        = t_ff >= LIMIT_SECONDS;
   assign yo_plus2   = yo_ff + 7'd2;
   assign leap       = yo_plus2[1:0] == 2'd0;
   assign ydays      = leap ? 9'd366 : 9'd365;
   assign year_step  = (yo_ff < YEAR_SPAN) && (days_ff >= {7'd0, ydays});
   assign mlen       = month_len(mon_ff, leap);
   assign month_step = (mon_ff < LAST_MONTH) && (days_ff >= {11'd0, mlen});
   assign days_plus4 = {1'b0, days_ff} + 17'd4;
   assign yy_full    = {1'b0, yo_ff} + YEAR_BASE_OFS;
   assign yy         = (yy_full >= 8'd100) ? 7'(yy_full - 8'd100) : yy_full[6:0];

   assign bcd_sec  = to_bcd({1'b0, sec_ff});
   assign bcd_min  = to_bcd({1'b0, min_ff});
   assign bcd_hour = to_bcd({2'd0, hour_ff});
   assign bcd_day  = to_bcd({2'd0, days_ff[4:0]} + 7'd1);
   assign bcd_mon  = to_bcd({3'd0, mon_ff} + 7'd1);
   assign bcd_year = to_bcd(yy);

   always_comb begin
      case (cmd.div_op)
         OP_DAY: begin
            div_dividend = t_ff;
         end
         OP_SEC: begin
            div_dividend = {15'd0, tod_ff};
         end
         OP_MIN: begin
            div_dividend = {21'd0, mt_ff};
         end
         default: begin
            div_dividend = {15'd0, days_plus4};
         end
      endcase
   end

   ebd_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .op        (cmd.div_op),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_r)
   );

   always_comb begin
      t_in      = t_ff;
      days_in   = days_ff;
      tod_in    = tod_ff;
      mt_in     = mt_ff;
      sec_in    = sec_ff;
      min_in    = min_ff;
      hour_in   = hour_ff;
      wd_in     = wd_ff;
      yo_in     = yo_ff;
      mon_in    = mon_ff;
      o_sec_in  = o_sec_ff;
      o_min_in  = o_min_ff;
      o_hour_in = o_hour_ff;
      o_wd_in   = o_wd_ff;
      o_day_in  = o_day_ff;
      o_mon_in  = o_mon_ff;
      o_year_in = o_year_ff;
      o_oor_in  = o_oor_ff;
      valid_in  = cmd.emit;

      if (cmd.load) begin
         t_in   = req_epoch_seconds;
         yo_in  = '0;
         mon_in = '0;
      end

      if (div_done) begin
         case (cmd.div_op)
            OP_DAY: begin
               days_in = div_q;
               tod_in  = div_r;
            end
            OP_SEC: begin
               sec_in = div_r[5:0];
               mt_in  = div_q[10:0];
            end
            OP_MIN: begin
               min_in  = div_r[5:0];
               hour_in = div_q[4:0];
            end
            default: begin
               wd_in = div_r[2:0];
            end
         endcase
      end

      if (cmd.year_en && year_step) begin
         days_in = days_ff - {7'd0, ydays};
         yo_in   = yo_ff + 7'd1;
      end

      if (cmd.month_en && month_step) begin
         days_in = days_ff - {11'd0, mlen};
         mon_in  = mon_ff + 4'd1;
      end

      if (cmd.emit) begin
         o_oor_in = oor;
         if (oor) begin
            o_sec_in  = '0;
            o_min_in  = '0;
            o_hour_in = '0;
            o_wd_in   = '0;
            o_day_in  = '0;
            o_mon_in  = '0;
            o_year_in = '0;
         end else begin
            o_sec_in  = bcd_sec[6:0];
            o_min_in  = bcd_min[6:0];
            o_hour_in = bcd_hour[5:0];
            o_wd_in   = wd_ff;
            o_day_in  = bcd_day[5:0];
            o_mon_in  = bcd_mon[4:0];
            o_year_in = bcd_year;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      t_ff      <= t_in;
      days_ff   <= days_in;
      tod_ff    <= tod_in;
      mt_ff     <= mt_in;
      sec_ff    <= sec_in;
      min_ff    <= min_in;
      hour_ff   <= hour_in;
      wd_ff     <= wd_in;
      yo_ff     <= yo_in;
      mon_ff    <= mon_in;
      o_sec_ff  <= o_sec_in;
      o_min_ff  <= o_min_in;
      o_hour_ff <= o_hour_in;
      o_wd_ff   <= o_wd_in;
      o_day_ff  <= o_day_in;
      o_mon_ff  <= o_mon_in;
      o_year_ff <= o_year_in;
      o_oor_ff  <= o_oor_in;
   end

   assign sts.oor        = oor;
   assign sts.div_done   = div_done;
   assign sts.year_done  = !year_step;
   assign sts.month_done = !month_step;

   assign rsp_valid        = valid_ff;
   assign rsp_second_bcd   = o_sec_ff;
   assign rsp_minute_bcd   = o_min_ff;
   assign rsp_hour_bcd     = o_hour_ff;
   assign rsp_weekday      = o_wd_ff;
   assign rsp_day_bcd      = o_day_ff;
   assign rsp_month_bcd    = o_mon_ff;
   assign rsp_year_bcd     = o_year_ff;
   assign rsp_out_of_range = o_oor_ff;

   `ASSERT_IMPLIES(a_year_bound, cmd.month_en, yo_ff < YEAR_SPAN, "year walk overran")
   `ASSERT_IMPLIES(a_oor_zero, valid_ff && o_oor_ff, o_day_ff == '0 && o_mon_ff == '0, "oor item not zeroed")

endmodule

FILE: rtl/ebd_ctrl.sv
`include "assert_macros.svh"

module ebd_ctrl import ebd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   output cmd_type cmd,
   input  sts_type sts
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ISSUE = 3'd2;
   localparam logic [2:0] S_WAIT  = 3'd3;
   localparam logic [2:0] S_YEAR  = 3'd4;
   localparam logic [2:0] S_MONTH = 3'd5;
   localparam logic [2:0] S_DONE  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] op_ff, op_in;

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      cmd.load      = 1'b0;
      cmd.div_start = 1'b0;
      cmd.div_op    = op_ff;
      cmd.year_en   = 1'b0;
      cmd.month_en  = 1'b0;
      cmd.emit      = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            op_in = OP_DAY;
            state_in = sts.oor ? S_DONE : S_ISSUE;
         end
         S_ISSUE: begin
            cmd.div_start = 1'b1;
            state_in      = S_WAIT;
         end
         S_WAIT: begin
            if (sts.div_done) begin
               case (op_ff)
                  OP_DAY: begin
                     op_in    = OP_SEC;
                     state_in = S_ISSUE;
                  end
                  OP_SEC: begin
                     op_in    = OP_MIN;
                     state_in = S_ISSUE;
                  end
                  OP_MIN: begin
                     op_in    = OP_WEEK;
                     state_in = S_ISSUE;
                  end
                  default: begin
                     state_in = S_YEAR;
                  end
               endcase
            end
         end
         S_YEAR: begin
            cmd.year_en = 1'b1;
            if (sts.year_done) begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            cmd.month_en = 1'b1;
            if (sts.month_done) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_DAY;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign busy = state_ff != S_IDLE;

   `ASSERT_IMPLIES(a_done_in_wait, sts.div_done, state_ff == S_WAIT, "divider done outside wait")

endmodule
